>>> src/mts_pkg.sv
`default_nettype none
package mts_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // what every cell of a chain does
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } chain_op_e;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic [1:0]              status;
  } rsp_t;

endpackage
`default_nettype wire

>>> src/mts_if.sv
`default_nettype none
interface mts_req_if;
  import mts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic signed [DataW-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface mts_rsp_if;
  import mts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] data;
  logic [1:0]              status;

  modport source (output valid, output data, output status, input ready);
  modport sink   (input valid, input data, input status, output ready);
endinterface
`default_nettype wire

>>> src/mts_cell.sv
`default_nettype none
module mts_cell (
  input  wire                               clk_i,
  input  wire mts_pkg::chain_op_e           op_i,
  input  wire logic signed [mts_pkg::DataW-1:0] above_i,
  input  wire logic signed [mts_pkg::DataW-1:0] below_i,
  output logic signed [mts_pkg::DataW-1:0]  data_o
);
  import mts_pkg::*;

  logic signed [DataW-1:0] data_d, data_q;

  always_comb begin
    unique case (op_i)
      OP_PUSH: data_d = above_i;
      OP_POP:  data_d = below_i;
      default: data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

>>> src/mts_chain.sv
`default_nettype none
module mts_chain (
  input  wire                                   clk_i,
  input  wire mts_pkg::chain_op_e               op_i,
  input  wire logic signed [mts_pkg::DataW-1:0] push_data_i,
  output logic signed [mts_pkg::DataW-1:0]      top_o
);
  import mts_pkg::*;

  logic signed [DataW-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] above, below;

    if (i == 0) begin : g_first
      assign above = push_data_i;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end

    // bottom cell pulls in a don't-care, never read below the count
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_data[i+1];
    end

    mts_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_data[i])
    );
  end

  assign top_o = cell_data[0];
endmodule
`default_nettype wire

>>> src/max_tracking_stack.sv
`default_nettype none
// Bounded stack of signed 32-bit values that also reports its running
// maximum. Each request is a push, a pop or a max query and yields exactly
// one response: pop returns the top element, query returns the maximum,
// push returns zero; a push on a full stack answers status full, a pop or
// query on an empty stack answers status empty, both with data zero. An
// unused command code changes nothing and answers zero / ok. Storage is two
// rows of shift cells (element stack and running-max stack), DEPTH deep,
// whose top cells always hold the current tops, so one request is taken
// every clock cycle unless the skid register is full; the response is
// registered in the output register, or in the skid register while the
// output stalls. A two-entry output stage (output register plus skid
// register) keeps requests flowing while a response waits. There is no
// clearing pass after reset: only the counts and valid flags reset; cells below go unread.
module max_tracking_stack (
  input  wire        clk_i,
  input  wire        rst_ni,
  mts_req_if.sink    req_i,
  mts_rsp_if.source  rsp_o
);
  import mts_pkg::*;

  // occupancy of both stacks
  logic [CountW-1:0] value_count_d, value_count_q;
  logic [CountW-1:0] max_count_d, max_count_q;

  // output register and skid stage
  logic out_valid_q, skid_valid_q;
  rsp_t out_q, skid_q;

  logic signed [DataW-1:0] value_top, max_top;
  chain_op_e               value_op, max_op;
  rsp_t                    res;
  logic                    fire;
  logic                    value_full, value_empty, max_empty;

  assign req_i.ready = !skid_valid_q;
  assign fire        = req_i.valid && req_i.ready;

  assign value_full  = (value_count_q == CountW'(DEPTH));
  assign value_empty = (value_count_q == '0);
  assign max_empty   = (max_count_q == '0);

  // command decode, computed from the cached tops
  always_comb begin
    value_op      = OP_HOLD;
    max_op        = OP_HOLD;
    value_count_d = value_count_q;
    max_count_d   = max_count_q;
    res.data      = '0;
    res.status    = ST_OK;
    if (fire) begin
      unique case (req_i.command)
        CMD_PUSH: begin
          if (value_full) begin
            res.status = ST_FULL;
          end else begin
            value_op      = OP_PUSH;
            value_count_d = value_count_q + CountW'(1);
            // new maximum, ties included so duplicates pop correctly
            if (max_empty || (req_i.value >= max_top)) begin
              max_op      = OP_PUSH;
              max_count_d = max_count_q + CountW'(1);
            end
          end
        end
        CMD_POP: begin
          if (value_empty) begin
            res.status = ST_EMPTY;
          end else begin
            value_op      = OP_POP;
            value_count_d = value_count_q - CountW'(1);
            res.data      = value_top;
            if (!max_empty && (max_top == value_top)) begin
              max_op      = OP_POP;
              max_count_d = max_count_q - CountW'(1);
            end
          end
        end
        CMD_QUERY: begin
          if (max_empty) begin
            res.status = ST_EMPTY;
          end else begin
            res.data = max_top;
          end
        end
        default: begin
          // unused code: no state change, zero / ok
        end
      endcase
    end
  end

  mts_chain u_value_chain (
    .clk_i       (clk_i),
    .op_i        (value_op),
    .push_data_i (req_i.value),
    .top_o       (value_top)
  );

  mts_chain u_max_chain (
    .clk_i       (clk_i),
    .op_i        (max_op),
    .push_data_i (req_i.value),
    .top_o       (max_top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_count_q <= '0;
      max_count_q   <= '0;
    end else begin
      value_count_q <= value_count_d;
      max_count_q   <= max_count_d;
    end
  end

  // output control: a stalled output pushes a new response into the skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !rsp_o.ready) begin
      if (fire) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= fire;
    end
  end

  // response payload, no reset
  always_ff @(posedge clk_i) begin
    if (out_valid_q && !rsp_o.ready) begin
      if (fire) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (fire) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.data   = out_q.data;
  assign rsp_o.status = out_q.status;

`ifndef ASSERT_OFF
  // running-max stack never holds more entries than the element stack
  a_max_le_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_count_q <= value_count_q)
    else $error("max stack deeper than element stack");

  // skid register only fills behind a stalled output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a response while output is empty");

  // a push that fits grows the element stack by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (req_i.command == CMD_PUSH) && !value_full)
    |=> (value_count_q == $past(value_count_q) + CountW'(1)))
    else $error("push did not grow the element stack");

  // a pop on a nonempty stack returns the cached top next cycle
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (req_i.command == CMD_POP) && !value_empty && !out_valid_q
     && !skid_valid_q)
    |=> (out_valid_q && (out_q.data == $past(value_top))
         && (out_q.status == ST_OK)))
    else $error("pop response does not match stack top");
`endif
endmodule
`default_nettype wire
